// File: rtl/apsd_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and sample conversion for the ADC packet deframer.
package apsd_pkg;

    localparam int PACKET_WORDS_DEF       = 221;
    localparam int HEADER_WORDS_DEF       = 21;
    localparam int SAMPLES_PER_PACKET_DEF = 200;

    localparam int WORD_W    = 16;
    localparam int POS_W     = 8;
    localparam int LANE_W    = 2;
    localparam int ADC_W     = 8;
    localparam int CHANNEL_W = ADC_W + LANE_W;
    localparam int SAMPLE_W  = 13;
    localparam int INDEX_W   = 6;
    localparam int LANES     = 4;

    // header word positions
    localparam logic [POS_W-1:0] POS_PACKET_ID = 8'd2;
    localparam logic [POS_W-1:0] POS_FRAME_ID  = 8'd4;
    localparam logic [POS_W-1:0] POS_ADC_ID    = 8'd19;

    localparam logic [11:0]         OFFSET_FLIP = 12'h800;
    localparam logic [SAMPLE_W-1:0] FULL_SCALE  = 13'd4096;

    typedef struct packed {
        logic [WORD_W-1:0]  word;
        logic [LANE_W-1:0]  lane;
        logic [INDEX_W-1:0] sample_index;
        logic               end_of_packet;
        logic [ADC_W-1:0]   adc_id;
        logic [WORD_W-1:0]  frame_id;
        logic [WORD_W-1:0]  packet_id;
    } apsd_slot_t;

    // byte swap, keep the upper 12 bits, flip two's complement <-> offset binary
    function automatic logic [11:0] convert_word(input logic [WORD_W-1:0] w);
        logic [11:0] raw12;
        raw12 = {w[7:0], w[15:12]};
        return raw12 ^ OFFSET_FLIP;
    endfunction

endpackage

// File: rtl/apsd_if.sv
`timescale 1ns / 1ps
// Channel interfaces: raw word input, sample output, configuration write.
interface apsd_word_if;
    logic                        valid;
    logic                        ready;
    logic [apsd_pkg::WORD_W-1:0] word;
    logic                        last_of_bank;

    modport source (output valid, output word, output last_of_bank, input ready);
    modport sink   (input valid, input word, input last_of_bank, output ready);
endinterface

interface apsd_sample_if;
    logic                           valid;
    logic                           ready;
    logic [apsd_pkg::CHANNEL_W-1:0] channel;
    logic [apsd_pkg::SAMPLE_W-1:0]  sample;
    logic [apsd_pkg::INDEX_W-1:0]   sample_index;
    logic [apsd_pkg::WORD_W-1:0]    frame_id;
    logic [apsd_pkg::WORD_W-1:0]    packet_id;
    logic                           end_of_packet;

    modport source (output valid, output channel, output sample, output sample_index,
                    output frame_id, output packet_id, output end_of_packet, input ready);
    modport sink   (input valid, input channel, input sample, input sample_index,
                    input frame_id, input packet_id, input end_of_packet, output ready);
endinterface

interface apsd_cfg_if;
    logic                       valid;
    logic                       ready;
    logic [apsd_pkg::LANES-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/adc_packet_sample_deframer.sv
`timescale 1ns / 1ps
// Top level of the ADC packet sample deframer.
//
//  channel   dir   payload                                          handshake
//  words     in    word, last_of_bank                               valid/ready
//  samples   out   channel, sample, sample_index, frame_id,         valid/ready
//                  packet_id, end_of_packet
//  cfg       in    data (invert_mask)                               valid/ready
//
// One word per cycle unless the output stalls; a taken word passes the slot register,
// then the result register, before its sample comes out. Header words give no result.
// Reset clears position and header state, invert_mask comes up as 5.
// A stalled result holds the slot register; words stall only when both are full.
module adc_packet_sample_deframer #(
    parameter int PACKET_WORDS       = apsd_pkg::PACKET_WORDS_DEF,
    parameter int HEADER_WORDS       = apsd_pkg::HEADER_WORDS_DEF,
    parameter int SAMPLES_PER_PACKET = apsd_pkg::SAMPLES_PER_PACKET_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    apsd_word_if.sink     words,
    apsd_sample_if.source samples,
    apsd_cfg_if.sink      cfg
);

    logic                 slot_valid;
    logic                 slot_ready;
    apsd_pkg::apsd_slot_t slot;

    apsd_framer #(
        .PACKET_WORDS       (PACKET_WORDS),
        .HEADER_WORDS       (HEADER_WORDS),
        .SAMPLES_PER_PACKET (SAMPLES_PER_PACKET)
    ) u_framer (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (words),
        .slot_valid (slot_valid),
        .slot       (slot),
        .slot_ready (slot_ready)
    );

    apsd_convert u_convert (
        .clk        (clk),
        .rst_n      (rst_n),
        .slot_valid (slot_valid),
        .slot       (slot),
        .slot_ready (slot_ready),
        .cfg        (cfg),
        .samples    (samples)
    );

endmodule

// File: rtl/apsd_framer.sv
`timescale 1ns / 1ps
// Packet position tracking, header capture and sample slot register.
module apsd_framer #(
    parameter int PACKET_WORDS       = apsd_pkg::PACKET_WORDS_DEF,
    parameter int HEADER_WORDS       = apsd_pkg::HEADER_WORDS_DEF,
    parameter int SAMPLES_PER_PACKET = apsd_pkg::SAMPLES_PER_PACKET_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    apsd_word_if.sink            words,
    output logic                 slot_valid,
    output apsd_pkg::apsd_slot_t slot,
    input  logic                 slot_ready
);

    localparam int SAMPLE_END_RAW = HEADER_WORDS + SAMPLES_PER_PACKET;
    localparam int SAMPLE_END     = (SAMPLE_END_RAW > PACKET_WORDS) ? PACKET_WORDS
                                                                    : SAMPLE_END_RAW;
    localparam logic [apsd_pkg::POS_W-1:0] HDR_END  = apsd_pkg::POS_W'(HEADER_WORDS);
    localparam logic [apsd_pkg::POS_W-1:0] SMP_END  = apsd_pkg::POS_W'(SAMPLE_END);
    localparam logic [apsd_pkg::POS_W-1:0] SMP_LAST = apsd_pkg::POS_W'(SAMPLE_END - 1);
    localparam logic [apsd_pkg::POS_W-1:0] PKT_LAST = apsd_pkg::POS_W'(PACKET_WORDS - 1);
    localparam logic [apsd_pkg::INDEX_W-1:0] LAST_INDEX =
        apsd_pkg::INDEX_W'((SAMPLE_END - 1 - HEADER_WORDS) / 4);

    logic [apsd_pkg::POS_W-1:0]  word_position_reg, word_position_next;
    logic [apsd_pkg::ADC_W-1:0]  adc_id_reg, adc_id_next;
    logic [apsd_pkg::WORD_W-1:0] frame_id_reg, frame_id_next;
    logic [apsd_pkg::WORD_W-1:0] packet_id_reg, packet_id_next;
    logic                        slot_valid_reg, slot_valid_next;
    apsd_pkg::apsd_slot_t        slot_reg, slot_next;

    logic                        accept;
    logic                        in_header;
    logic                        in_samples;
    logic [apsd_pkg::POS_W-1:0]  sample_offset;

    assign words.ready = !slot_valid_reg || slot_ready;
    assign accept      = words.valid && words.ready;

    assign in_header     = word_position_reg < HDR_END;
    assign in_samples    = !in_header && (word_position_reg < SMP_END);
    assign sample_offset = word_position_reg - HDR_END;

    always_comb
    begin
        word_position_next = word_position_reg;
        adc_id_next        = adc_id_reg;
        frame_id_next      = frame_id_reg;
        packet_id_next     = packet_id_reg;
        slot_valid_next    = slot_valid_reg;
        slot_next          = slot_reg;

        if (slot_ready)
        begin
            slot_valid_next = 1'b0;
        end

        if (accept)
        begin
            if (in_header)
            begin
                unique case (word_position_reg)
                    apsd_pkg::POS_PACKET_ID:
                    begin
                        packet_id_next = words.word;
                    end
                    apsd_pkg::POS_FRAME_ID:
                    begin
                        frame_id_next = words.word;
                    end
                    apsd_pkg::POS_ADC_ID:
                    begin
                        adc_id_next = words.word[15:8];
                    end
                    default:
                    begin
                    end
                endcase
            end

            slot_valid_next         = in_samples;
            slot_next.word          = words.word;
            slot_next.lane          = sample_offset[1:0];
            slot_next.sample_index  = sample_offset[7:2];
            slot_next.end_of_packet = (word_position_reg == SMP_LAST);
            slot_next.adc_id        = adc_id_reg;
            slot_next.frame_id      = frame_id_reg;
            slot_next.packet_id     = packet_id_reg;

            if (words.last_of_bank || (word_position_reg == PKT_LAST))
            begin
                word_position_next = '0;
            end
            else
            begin
                word_position_next = word_position_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_position_reg <= '0;
            adc_id_reg        <= '0;
            frame_id_reg      <= '0;
            packet_id_reg     <= '0;
            slot_valid_reg    <= 1'b0;
        end
        else
        begin
            word_position_reg <= word_position_next;
            adc_id_reg        <= adc_id_next;
            frame_id_reg      <= frame_id_next;
            packet_id_reg     <= packet_id_next;
            slot_valid_reg    <= slot_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot_valid = slot_valid_reg;
    assign slot       = slot_reg;

    a_pos_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
        word_position_reg <= PKT_LAST)
        else $error("word position ran past the packet");

    a_bank_end_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && words.last_of_bank) |=> (word_position_reg == '0))
        else $error("position not cleared after bank end");

    a_eop_index: assert property (@(posedge clk) disable iff (!rst_n)
        (slot_valid_reg && slot_reg.end_of_packet) |-> (slot_reg.sample_index == LAST_INDEX))
        else $error("end of packet on wrong sample index");

endmodule

// File: rtl/apsd_convert.sv
`timescale 1ns / 1ps
// Sample conversion, lane polarity inversion and result register.
module apsd_convert (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 slot_valid,
    input  apsd_pkg::apsd_slot_t slot,
    output logic                 slot_ready,
    apsd_cfg_if.sink             cfg,
    apsd_sample_if.source        samples
);

    logic [apsd_pkg::LANES-1:0]     invert_mask_reg, invert_mask_next;
    logic                           out_valid_reg, out_valid_next;
    logic [apsd_pkg::CHANNEL_W-1:0] channel_reg, channel_next;
    logic [apsd_pkg::SAMPLE_W-1:0]  sample_reg, sample_next;
    logic [apsd_pkg::INDEX_W-1:0]   index_reg, index_next;
    logic [apsd_pkg::WORD_W-1:0]    frame_reg, frame_next;
    logic [apsd_pkg::WORD_W-1:0]    packet_reg, packet_next;
    logic                           eop_reg, eop_next;

    logic [11:0]                    converted;
    logic                           load;

    assign cfg.ready  = 1'b1;
    assign slot_ready = !out_valid_reg || samples.ready;
    assign load       = slot_valid && slot_ready;
    assign converted  = apsd_pkg::convert_word(slot.word);

    always_comb
    begin
        invert_mask_next = invert_mask_reg;
        out_valid_next   = out_valid_reg;
        channel_next     = channel_reg;
        sample_next      = sample_reg;
        index_next       = index_reg;
        frame_next       = frame_reg;
        packet_next      = packet_reg;
        eop_next         = eop_reg;

        if (cfg.valid)
        begin
            invert_mask_next = cfg.data;
        end

        if (samples.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (load)
        begin
            out_valid_next = 1'b1;
            channel_next   = {slot.adc_id, slot.lane};
            if (invert_mask_reg[slot.lane])
            begin
                sample_next = apsd_pkg::FULL_SCALE - {1'b0, converted};
            end
            else
            begin
                sample_next = {1'b0, converted};
            end
            index_next  = slot.sample_index;
            frame_next  = slot.frame_id;
            packet_next = slot.packet_id;
            eop_next    = slot.end_of_packet;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            invert_mask_reg <= 4'd5;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            invert_mask_reg <= invert_mask_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        channel_reg <= channel_next;
        sample_reg  <= sample_next;
        index_reg   <= index_next;
        frame_reg   <= frame_next;
        packet_reg  <= packet_next;
        eop_reg     <= eop_next;
    end

    assign samples.valid         = out_valid_reg;
    assign samples.channel       = channel_reg;
    assign samples.sample        = sample_reg;
    assign samples.sample_index  = index_reg;
    assign samples.frame_id      = frame_reg;
    assign samples.packet_id     = packet_reg;
    assign samples.end_of_packet = eop_reg;

    a_sample_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (sample_reg <= apsd_pkg::FULL_SCALE))
        else $error("sample out of range");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded sample not presented");

    a_slot_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !samples.ready) |-> !slot_ready)
        else $error("slot taken while result is stalled");

endmodule

// File: tb/apsd_sample_checker.sv
`timescale 1ns / 1ps
// Checker for the ADC packet deframer: tracks packet state, predicts samples, compares.
module apsd_sample_checker (
    input  logic   clk,
    input  logic   rst_n,
    apsd_word_if   words,
    apsd_sample_if samples,
    apsd_cfg_if    cfg,
    output int     fail_count,
    output int     pending
);

    localparam int HEADER_WORDS = apsd_pkg::HEADER_WORDS_DEF;
    localparam int PACKET_WORDS = apsd_pkg::PACKET_WORDS_DEF;
    localparam int SAMPLE_END   =
        (apsd_pkg::HEADER_WORDS_DEF + apsd_pkg::SAMPLES_PER_PACKET_DEF
         > apsd_pkg::PACKET_WORDS_DEF) ? apsd_pkg::PACKET_WORDS_DEF
        : apsd_pkg::HEADER_WORDS_DEF + apsd_pkg::SAMPLES_PER_PACKET_DEF;
    localparam logic [apsd_pkg::LANES-1:0] INVERT_MASK_RESET = 4'd5;
    localparam int MAX_PRINTED  = 100;
    localparam int EXP_DEPTH    = 16;

    typedef struct packed {
        logic [apsd_pkg::CHANNEL_W-1:0] channel;
        logic [apsd_pkg::SAMPLE_W-1:0]  sample;
        logic [apsd_pkg::INDEX_W-1:0]   sample_index;
        logic [apsd_pkg::WORD_W-1:0]    frame_id;
        logic [apsd_pkg::WORD_W-1:0]    packet_id;
        logic                           end_of_packet;
    } sample_t;

    logic [apsd_pkg::POS_W-1:0]  word_pos;
    logic [apsd_pkg::ADC_W-1:0]  adc_id_q;
    logic [apsd_pkg::WORD_W-1:0] frame_id_q;
    logic [apsd_pkg::WORD_W-1:0] packet_id_q;
    logic [apsd_pkg::LANES-1:0]  invert_mask_q;
    sample_t                     expected_samples[EXP_DEPTH];
    logic [3:0]                  exp_rd_ptr;
    logic [3:0]                  exp_wr_ptr;
    int                          exp_count;
    int                          mismatches;

    task automatic report_mismatch(input string msg);
        if (mismatches < MAX_PRINTED)
        begin
            $display("%0t ns: sample mismatch: %s", $time, msg);
        end
        mismatches++;
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
        end
    endtask

    task automatic store_expected(input sample_t s);
        if (exp_count >= EXP_DEPTH)
        begin
            report_mismatch("expected sample store overflow");
        end
        else
        begin
            expected_samples[exp_wr_ptr] = s;
            exp_wr_ptr = exp_wr_ptr + 1'b1;
            exp_count++;
        end
    endtask

    // advance the packet position by one word; sample words queue a result
    task automatic deframe_word(input logic [apsd_pkg::WORD_W-1:0] w, input logic last);
        sample_t                     s;
        logic [apsd_pkg::POS_W-1:0]  idx;
        logic [apsd_pkg::LANE_W-1:0] lane;
        logic [apsd_pkg::WORD_W-1:0] swapped;
        logic [11:0]                 code;
        if (word_pos < HEADER_WORDS)
        begin
            if (word_pos == apsd_pkg::POS_PACKET_ID)
                packet_id_q = w;
            else if (word_pos == apsd_pkg::POS_FRAME_ID)
                frame_id_q = w;
            else if (word_pos == apsd_pkg::POS_ADC_ID)
                adc_id_q = w[15:8];
        end
        else if (word_pos < SAMPLE_END)
        begin
            idx     = apsd_pkg::POS_W'(word_pos - HEADER_WORDS);
            lane    = idx[apsd_pkg::LANE_W-1:0];
            swapped = {w[7:0], w[15:8]};
            // top bit flip: two's complement <-> offset binary
            code    = {~swapped[15], swapped[14:4]};
            s.channel       = {adc_id_q, lane};
            s.sample        = invert_mask_q[lane] ? apsd_pkg::FULL_SCALE - {1'b0, code}
                                                  : {1'b0, code};
            s.sample_index  = idx[apsd_pkg::INDEX_W+1:2];
            s.frame_id      = frame_id_q;
            s.packet_id     = packet_id_q;
            s.end_of_packet = (word_pos + 1 == SAMPLE_END);
            store_expected(s);
        end
        if (last || word_pos + 1 >= PACKET_WORDS)
            word_pos = '0;
        else
            word_pos = word_pos + 1'b1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sample_t want;
        if (!rst_n)
        begin
            word_pos      = '0;
            adc_id_q      = '0;
            frame_id_q    = '0;
            packet_id_q   = '0;
            invert_mask_q = INVERT_MASK_RESET;
            mismatches    = 0;
            exp_rd_ptr    = '0;
            exp_wr_ptr    = '0;
            exp_count     = 0;
            fail_count   <= 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                invert_mask_q = cfg.data;
            // samples leave only after their word has passed the slot and result registers, so pop before push
            if (samples.valid && samples.ready)
            begin
                if (exp_count == 0)
                begin
                    report_mismatch($sformatf("unexpected transaction on channel %0d",
                                              samples.channel));
                end
                else
                begin
                    want       = expected_samples[exp_rd_ptr];
                    exp_rd_ptr = exp_rd_ptr + 1'b1;
                    exp_count--;
                    check_field("channel", int'(samples.channel), int'(want.channel));
                    check_field("sample", int'(samples.sample), int'(want.sample));
                    check_field("sample_index", int'(samples.sample_index),
                                int'(want.sample_index));
                    check_field("frame_id", int'(samples.frame_id), int'(want.frame_id));
                    check_field("packet_id", int'(samples.packet_id), int'(want.packet_id));
                    check_field("end_of_packet", int'(samples.end_of_packet),
                                int'(want.end_of_packet));
                end
            end
            if (words.valid && words.ready)
                deframe_word(words.word, words.last_of_bank);
            pending    <= exp_count;
            fail_count <= mismatches;
        end
    end

endmodule

// File: tb/tb_adc_packet_sample_deframer.sv
`timescale 1ns / 1ps
// Top of the ADC packet deframer testbench: clock, reset, word and mask stimulus, verdict.
module tb_adc_packet_sample_deframer;

    localparam int ITEM_TARGET    = 1850;
    localparam int CALM_TAIL      = 300;
    localparam int DRAIN_CYCLES   = 6;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;

    logic clk;
    logic rst_n;

    apsd_word_if   word_ch();
    apsd_sample_if sample_ch();
    apsd_cfg_if    cfg_ch();

    int mismatch_total;
    int samples_outstanding;

    int word_count  = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;
    bit calm        = 1'b0;
    bit hold_wanted = 1'b0;
    bit hold_served = 1'b0;
    int idle_cycles = 0;

    adc_packet_sample_deframer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .words   (word_ch),
        .samples (sample_ch),
        .cfg     (cfg_ch)
    );

    apsd_sample_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .words      (word_ch),
        .samples    (sample_ch),
        .cfg        (cfg_ch),
        .fail_count (mismatch_total),
        .pending    (samples_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // sample sink: random stall bursts, plus one long hold on request
    initial
    begin
        int burst;
        sample_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_wanted && !hold_served)
            begin
                sample_ch.ready = 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
                hold_served = 1'b1;
            end
            else if (!calm && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
            begin
                burst = $urandom_range(1, 12);
                sample_ch.ready = 1'b0;
                repeat (burst - 1) @(negedge clk);
            end
            else
            begin
                sample_ch.ready = 1'b1;
            end
        end
    end

    // cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((word_ch.valid && word_ch.ready) || (sample_ch.valid && sample_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb_adc_packet_sample_deframer: FAIL");
                $finish;
            end
        end
    end

    function automatic logic [apsd_pkg::WORD_W-1:0] random_word();
        logic [apsd_pkg::WORD_W-1:0] corners[4] = '{16'h0000, 16'hffff, 16'h0080, 16'hff7f};
        if ($urandom_range(0, 7) == 0)
            return corners[$urandom_range(0, 3)];
        return apsd_pkg::WORD_W'($urandom_range(0, 16'hffff));
    endfunction

    task automatic send_word(input logic [apsd_pkg::WORD_W-1:0] w, input logic last);
        int gap;
        @(negedge clk);
        if (word_count >= ITEM_TARGET - CALM_TAIL)
            calm = 1'b1;
        if (!calm && gap_pct > 0 && $urandom_range(0, 99) < gap_pct)
        begin
            gap = $urandom_range(1, 12);
            word_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        word_ch.valid        = 1'b1;
        word_ch.word         = w;
        word_ch.last_of_bank = last;
        do
            @(posedge clk);
        while (!word_ch.ready);
        word_count++;
    endtask

    task automatic wait_for_drain();
        @(negedge clk);
        word_ch.valid = 1'b0;
        while (samples_outstanding != 0) @(posedge clk);
        // header words in flight give no sample, allow for them too
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_invert_mask(input logic [apsd_pkg::LANES-1:0] mask);
        wait_for_drain();
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.data  = mask;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // full packets mostly; some cut short by a bank end, some with bank end on the last word
    task automatic send_packet();
        int   length;
        int   pick;
        logic bank_end;
        length   = apsd_pkg::PACKET_WORDS_DEF;
        bank_end = 1'b0;
        pick     = $urandom_range(0, 99);
        if (pick < 20)
        begin
            length   = $urandom_range(1, apsd_pkg::PACKET_WORDS_DEF - 1);
            bank_end = 1'b1;
        end
        else if (pick < 30)
        begin
            bank_end = 1'b1;
        end
        for (int n = 0; n < length && word_count < ITEM_TARGET; n++)
            send_word(random_word(), bank_end && (n == length - 1));
    endtask

    initial
    begin
        logic [apsd_pkg::WORD_W-1:0] corner_samples[4] =
            '{16'h0000, 16'hffff, 16'h0080, 16'hf07f};
        logic [apsd_pkg::WORD_W-1:0] w;
        int                          phase;
        int                          phase_start;
        int                          pcts[3] = '{0, 15, 40};

        rst_n                = 1'b0;
        word_ch.valid        = 1'b0;
        word_ch.word         = '0;
        word_ch.last_of_bank = 1'b0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.data          = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: extreme header ids, top ADC id, one corner word per lane, bank end
        for (int n = 0; n < apsd_pkg::HEADER_WORDS_DEF; n++)
        begin
            w = random_word();
            if (n == apsd_pkg::POS_PACKET_ID)
                w = 16'hffff;
            else if (n == apsd_pkg::POS_FRAME_ID)
                w = 16'h0000;
            else if (n == apsd_pkg::POS_ADC_ID)
                w = 16'hff00;
            send_word(w, 1'b0);
        end
        for (int n = 0; n < apsd_pkg::LANES; n++)
            send_word(corner_samples[n], n == apsd_pkg::LANES - 1);

        phase = 0;
        while (word_count < ITEM_TARGET)
        begin
            if (phase == 0)
                write_invert_mask(4'hf);
            else if (phase == 1)
                write_invert_mask(4'h0);
            else
                write_invert_mask(apsd_pkg::LANES'($urandom_range(0, 15)));
            gap_pct   = (phase == 1) ? 0 : pcts[$urandom_range(0, 2)];
            stall_pct = (phase == 1) ? 0 : pcts[$urandom_range(0, 2)];
            if (phase == 2)
                hold_wanted = 1'b1;
            phase_start = word_count;
            while (word_count - phase_start < apsd_pkg::PACKET_WORDS_DEF
                   && word_count < ITEM_TARGET)
                send_packet();
            phase++;
        end

        wait_for_drain();
        if (mismatch_total == 0)
            $display("tb_adc_packet_sample_deframer: PASS");
        else
            $display("tb_adc_packet_sample_deframer: FAIL");
        $finish;
    end

endmodule

// File: files.f
rtl/apsd_pkg.sv
rtl/apsd_if.sv
rtl/apsd_framer.sv
rtl/apsd_convert.sv
rtl/adc_packet_sample_deframer.sv
tb/apsd_sample_checker.sv
tb/tb_adc_packet_sample_deframer.sv
